### design/dtr_pkg.sv
`timescale 1ns / 1ps

package dtr_pkg;

   // Beat kinds on the request channel
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // Register map
   localparam logic [15:0] ADDR_DIV  = 16'hFF04;
   localparam logic [15:0] ADDR_TIMA = 16'hFF05;
   localparam logic [15:0] ADDR_TMA  = 16'hFF06;
   localparam logic [15:0] ADDR_TAC  = 16'hFF07;

   // Reset values
   localparam logic [15:0] SYSTEM_COUNT_RESET = 16'hAB00;
   localparam logic [7:0]  CONTROL_RESET      = 8'hF8;

   // Reload countdown: all ones is idle, a reload fires when it reaches zero
   localparam logic [4:0] CD_IDLE  = 5'h1F;
   localparam logic [4:0] CD_START = 5'd8;
   localparam logic [4:0] CD_CANCEL_LO = 5'd5;
   localparam logic [4:0] CD_IGNORE_LO = 5'd1;
   localparam logic [4:0] CD_IGNORE_HI = 5'd4;

   localparam int TICKS_PER_CYCLE = 4;

   typedef struct packed {
      logic [15:0] system_count;
      logic [7:0]  tick_count;
      logic [7:0]  reload_value;
      logic [7:0]  control_byte;
      logic [4:0]  reload_countdown;
   } state_type;

   localparam state_type STATE_RESET = '{
      system_count:     SYSTEM_COUNT_RESET,
      tick_count:       8'h00,
      reload_value:     8'h00,
      control_byte:     CONTROL_RESET,
      reload_countdown: CD_IDLE
   };

endpackage

### design/dtr_step.sv
`timescale 1ns / 1ps

module dtr_step (
   input  dtr_pkg::state_type cur_state,
   input  logic [1:0]         mode,
   input  logic [15:0]        address,
   input  logic [7:0]         write_data,
   output dtr_pkg::state_type nxt_state,
   output logic [7:0]         read_data,
   output logic               timer_irq
);

   // Divider bit watched by each select code
   function automatic logic sel_bit(input logic [15:0] cnt, input logic [1:0] sel);
      case (sel)
         2'd0:    sel_bit = cnt[9];
         2'd1:    sel_bit = cnt[3];
         2'd2:    sel_bit = cnt[5];
         default: sel_bit = cnt[7];
      endcase
   endfunction

   // Falling edge of the watched bit: count just became a multiple of the period
   function automatic logic tick_hit(input logic [15:0] cnt, input logic [1:0] sel);
      case (sel)
         2'd0:    tick_hit = (cnt[9:0] == '0);
         2'd1:    tick_hit = (cnt[3:0] == '0);
         2'd2:    tick_hit = (cnt[5:0] == '0);
         default: tick_hit = (cnt[7:0] == '0);
      endcase
   endfunction

   logic old_bit;
   logic old_en;
   logic glitch_sel;
   logic glitch_en;

   assign old_bit    = sel_bit(cur_state.system_count, cur_state.control_byte[1:0]);
   assign old_en     = cur_state.control_byte[2];
   assign glitch_sel = old_bit && !sel_bit(cur_state.system_count, write_data[1:0]);
   assign glitch_en  = old_en && !write_data[2];

   always_comb begin
      nxt_state = cur_state;
      read_data = 8'h00;
      timer_irq = 1'b0;
      case (mode)
         dtr_pkg::MODE_TICK: begin
            // Unroll the four ticks of one machine cycle
            for (int i = 0; i < dtr_pkg::TICKS_PER_CYCLE; i++) begin
               nxt_state.system_count = nxt_state.system_count + 16'd1;
               if (nxt_state.reload_countdown != dtr_pkg::CD_IDLE) begin
                  nxt_state.reload_countdown = nxt_state.reload_countdown - 5'd1;
               end
               if (nxt_state.reload_countdown == dtr_pkg::CD_IDLE) begin
                  if (nxt_state.control_byte[2] &&
                      tick_hit(nxt_state.system_count, nxt_state.control_byte[1:0])) begin
                     if (nxt_state.tick_count == 8'hFF) begin
                        nxt_state.tick_count       = 8'h00;
                        nxt_state.reload_countdown = dtr_pkg::CD_START;
                     end else begin
                        nxt_state.tick_count = nxt_state.tick_count + 8'd1;
                     end
                  end
               end else if (nxt_state.reload_countdown == 5'd0) begin
                  nxt_state.tick_count = nxt_state.reload_value;
                  timer_irq            = 1'b1;
               end
            end
         end
         dtr_pkg::MODE_READ: begin
            case (address)
               dtr_pkg::ADDR_DIV:  read_data = cur_state.system_count[15:8];
               dtr_pkg::ADDR_TIMA: read_data = cur_state.tick_count;
               dtr_pkg::ADDR_TMA:  read_data = cur_state.reload_value;
               dtr_pkg::ADDR_TAC:  read_data = cur_state.control_byte;
               default:            read_data = 8'h00;
            endcase
         end
         dtr_pkg::MODE_WRITE: begin
            case (address)
               dtr_pkg::ADDR_DIV: begin
                  // Clearing the divider can drop the watched bit
                  nxt_state.system_count = 16'h0000;
                  nxt_state.tick_count   = cur_state.tick_count + {7'd0, old_bit};
               end
               dtr_pkg::ADDR_TIMA: begin
                  // Cancel a pending reload early on, ignore the write late in it
                  if (cur_state.reload_countdown >= dtr_pkg::CD_CANCEL_LO &&
                      cur_state.reload_countdown <= dtr_pkg::CD_START) begin
                     nxt_state.reload_countdown = dtr_pkg::CD_IDLE;
                     nxt_state.tick_count       = write_data;
                  end else if (!(cur_state.reload_countdown >= dtr_pkg::CD_IGNORE_LO &&
                                 cur_state.reload_countdown <= dtr_pkg::CD_IGNORE_HI)) begin
                     nxt_state.tick_count = write_data;
                  end
               end
               dtr_pkg::ADDR_TMA: begin
                  nxt_state.reload_value = write_data;
               end
               dtr_pkg::ADDR_TAC: begin
                  // Select change and disable each may add an early tick
                  nxt_state.control_byte = write_data;
                  nxt_state.tick_count   = cur_state.tick_count + {7'd0, glitch_sel}
                                         + {7'd0, glitch_en};
               end
               default: begin
                  nxt_state = cur_state;
               end
            endcase
         end
         default: begin
            nxt_state = cur_state;
         end
      endcase
   end

endmodule

### design/divider_timer_with_reload_top.sv
`timescale 1ns / 1ps

// Path: a request beat is captured in the request register, stepped, and held in the
// response register until taken; a response stalled by rsp_ready low holds the pipe.
// Throughput: one beat per cycle while responses are taken; the four ticks of a machine
// cycle are done in one pass of the step logic between request and response registers.
// Reset: synchronous, active high; the divider starts at 0xAB00, control at 0xF8,
// counter and modulo at zero, no reload pending, both pipeline registers empty.
module divider_timer_with_reload_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_timer_irq
);

   logic               req_valid_ff;
   logic [1:0]         mode_ff;
   logic [15:0]        address_ff;
   logic [7:0]         write_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         read_data_ff;
   logic               timer_irq_ff;
   logic               step_go;
   logic               req_valid_in;
   logic [7:0]         read_data_in;
   logic               timer_irq_in;
   dtr_pkg::state_type state_ff;
   dtr_pkg::state_type state_in;

   // Advance the held beat when the response register is free or draining
   assign step_go      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || step_go;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = step_go ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   dtr_step u_step (
      .cur_state  (state_ff),
      .mode       (mode_ff),
      .address    (address_ff),
      .write_data (write_data_ff),
      .nxt_state  (state_in),
      .read_data  (read_data_in),
      .timer_irq  (timer_irq_in)
   );

   // Control and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= dtr_pkg::STATE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff       <= req_mode;
         address_ff    <= req_address;
         write_data_ff <= req_write_data;
      end
   end

   // Hold the response beat until taken
   always_ff @(posedge clock) begin
      if (step_go) begin
         read_data_ff <= read_data_in;
         timer_irq_ff <= timer_irq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_timer_irq = timer_irq_ff;

endmodule
